>>> rtl/least_loaded_slot_store_defines.svh
// Assertion macros used by least_loaded_slot_store.sv
`ifndef LEAST_LOADED_SLOT_STORE_DEFINES_SVH
`define LEAST_LOADED_SLOT_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LLSS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llss assertion failed");
`define LLSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llss assertion failed");
`else
`define LLSS_ASSERT_IMPLIES(label, ante, cons)
`define LLSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/llss_pkg.sv
package llss_pkg;

    localparam int NUM_BUFFERS      = 2;
    localparam int SLOTS_PER_BUFFER = 8;

    localparam int BUF_W     = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int BUF_SUM_W = BUF_W + 1;
    localparam int SLOT_W    = (SLOTS_PER_BUFFER > 1) ? $clog2(SLOTS_PER_BUFFER) : 1;
    localparam int FILL_W    = $clog2(SLOTS_PER_BUFFER + 1);

    localparam int LIMIT_W      = 10;
    localparam int ITEM_W       = 10;
    localparam int START_W      = 4;
    localparam int STATUS_W     = 2;
    localparam int BUF_IDX_W    = 4;
    localparam int SLOT_IDX_W   = 6;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_FIELDS_W = BUF_IDX_W + SLOT_IDX_W + ITEM_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    localparam logic OP_PRODUCE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [BUF_IDX_W-1:0]  buffer_index;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [ITEM_W-1:0]     item_number;
    } result_t;

endpackage

>>> rtl/least_loaded_slot_store.sv
// Channel   Direction  tdata fields (low bit up)                  tuser
// s_axis    in         start_buffer[3:0]                          opcode[0]
// m_axis    out        buffer_index[3:0] slot_index[9:4]          status[1:0]
//                      item_number[19:10]
// cfg       in         cfg_wdata = item_limit, written on cfg_we  -
//
// One transaction per cycle sustained while m_axis is not stalled; an accepted transaction
// is held in the input register, then one pass of selection logic writes the result register.
// Buffer state updates as a transaction leaves the input register, so the next one sees it.
// Reset empties all buffers, clears both totals and sets item_limit to 100.
// A stalled m_axis holds the result; one more transaction waits in the input register.
`include "least_loaded_slot_store_defines.svh"

module least_loaded_slot_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [llss_pkg::LIMIT_W-1:0]       cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [llss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // start_buffer, zero pad
    input  logic [0:0]                         s_axis_tuser,  // opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [llss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // buffer_index, slot_index,
                                                              // item_number, zero pad
    output logic [llss_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);

    import llss_pkg::*;

    logic                     in_valid_reg;
    logic                     in_op_reg;
    logic [START_W-1:0]       in_start_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     slot_full_reg [NUM_BUFFERS][SLOTS_PER_BUFFER];
    logic [ITEM_W-1:0]        slot_item_reg [NUM_BUFFERS][SLOTS_PER_BUFFER];
    logic [FILL_W-1:0]        fill_count_reg [NUM_BUFFERS];
    logic [LIMIT_W-1:0]       produced_total_reg;
    logic [LIMIT_W-1:0]       consumed_total_reg;
    logic [LIMIT_W-1:0]       item_limit_reg;

    logic                     advance;
    logic                     in_fire;
    logic [BUF_W-1:0]         prod_buf;
    logic                     prod_found;
    logic [SLOT_W-1:0]        prod_slot;
    logic [BUF_W-1:0]         start_mod;
    logic [BUF_SUM_W-1:0]     rr_sum;
    logic                     cons_found;
    logic [BUF_W-1:0]         cons_buf;
    logic [SLOT_W-1:0]        cons_slot;
    logic [ITEM_W-1:0]        cons_item;
    logic [ITEM_W-1:0]        next_item;
    logic                     do_produce;
    logic                     do_consume;
    result_t                  result_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.item_number, out_reg.slot_index,
                            out_reg.buffer_index};

    // least loaded buffer, lowest index on a tie
    always_comb
    begin
        prod_buf = '0;
        for (int b = 1; b < NUM_BUFFERS; b++)
        begin
            if (fill_count_reg[b] < fill_count_reg[prod_buf])
                prod_buf = BUF_W'(b);
        end
    end

    always_comb
    begin
        prod_found = 1'b0;
        prod_slot  = '0;
        for (int s = SLOTS_PER_BUFFER - 1; s >= 0; s--)
        begin
            if (!slot_full_reg[prod_buf][s])
            begin
                prod_found = 1'b1;
                prod_slot  = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        start_mod = '0;
        for (int i = 0; i < (1 << START_W); i++)
        begin
            if (in_start_reg == START_W'(i))
                start_mod = BUF_W'(i % NUM_BUFFERS);
        end
    end

    // round-robin from the start buffer to the first non-empty one
    always_comb
    begin
        cons_found = 1'b0;
        cons_buf   = '0;
        rr_sum     = '0;
        for (int k = NUM_BUFFERS - 1; k >= 0; k--)
        begin
            rr_sum = {1'b0, start_mod} + BUF_SUM_W'(k);
            if (rr_sum >= BUF_SUM_W'(NUM_BUFFERS))
                rr_sum = rr_sum - BUF_SUM_W'(NUM_BUFFERS);
            if (fill_count_reg[rr_sum[BUF_W-1:0]] != '0)
            begin
                cons_found = 1'b1;
                cons_buf   = rr_sum[BUF_W-1:0];
            end
        end
    end

    always_comb
    begin
        cons_slot = '0;
        for (int s = SLOTS_PER_BUFFER - 1; s >= 0; s--)
        begin
            if (slot_full_reg[cons_buf][s])
                cons_slot = SLOT_W'(s);
        end
    end

    assign cons_item = slot_item_reg[cons_buf][cons_slot];
    assign next_item = produced_total_reg + ITEM_W'(1);

    always_comb
    begin
        result_next = '0;
        do_produce  = 1'b0;
        do_consume  = 1'b0;
        if (in_op_reg == OP_PRODUCE)
        begin
            if (produced_total_reg >= item_limit_reg)
                result_next.status = ST_LIMIT;
            else if (!prod_found)
                result_next.status = ST_FULL;
            else
            begin
                do_produce               = 1'b1;
                result_next.status       = ST_DONE;
                result_next.buffer_index = BUF_IDX_W'(prod_buf);
                result_next.slot_index   = SLOT_IDX_W'(prod_slot);
                result_next.item_number  = next_item;
            end
        end
        else
        begin
            if (consumed_total_reg >= item_limit_reg)
                result_next.status = ST_LIMIT;
            else if (!cons_found)
                result_next.status = ST_EMPTY;
            else
            begin
                do_consume               = 1'b1;
                result_next.status       = ST_DONE;
                result_next.buffer_index = BUF_IDX_W'(cons_buf);
                result_next.slot_index   = SLOT_IDX_W'(cons_slot);
                result_next.item_number  = cons_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg    <= s_axis_tuser[0];
            in_start_reg <= s_axis_tdata[START_W-1:0];
        end
        if (advance)
            out_reg <= result_next;
        if (advance && do_produce)
            slot_item_reg[prod_buf][prod_slot] <= next_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUFFERS; b++)
            begin
                fill_count_reg[b] <= '0;
                for (int s = 0; s < SLOTS_PER_BUFFER; s++)
                    slot_full_reg[b][s] <= 1'b0;
            end
            produced_total_reg <= '0;
            consumed_total_reg <= '0;
            item_limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
                item_limit_reg <= cfg_wdata;
            if (advance && do_produce)
            begin
                slot_full_reg[prod_buf][prod_slot] <= 1'b1;
                fill_count_reg[prod_buf]           <= fill_count_reg[prod_buf] + FILL_W'(1);
                produced_total_reg                 <= next_item;
            end
            if (advance && do_consume)
            begin
                slot_full_reg[cons_buf][cons_slot] <= 1'b0;
                fill_count_reg[cons_buf]           <= fill_count_reg[cons_buf] - FILL_W'(1);
                consumed_total_reg                 <= consumed_total_reg + LIMIT_W'(1);
            end
        end
    end

    `LLSS_ASSERT_IMPLIES(a_fail_fields_zero,
        out_valid_reg && out_reg.status != ST_DONE,
        out_reg.buffer_index == '0 && out_reg.slot_index == '0 && out_reg.item_number == '0)
    `LLSS_ASSERT_IMPLIES(a_ready_when_out_free, !out_valid_reg, s_axis_tready)
    `LLSS_ASSERT_NEXT(a_produce_advances_total, advance && do_produce,
        produced_total_reg == $past(produced_total_reg) + LIMIT_W'(1))
    `LLSS_ASSERT_NEXT(a_consume_not_ahead, advance && do_consume,
        consumed_total_reg <= $past(produced_total_reg))

endmodule
